[hw/rtl/sti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg
// Shared widths, scan phase codes, types and the digit decoder for the
// string to integer parser.
// ----------------------------------------------------------------------------
package sti_pkg;

    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int BASE_BITS  = 5;
    localparam int CHAR_BITS  = 8;
    localparam int PHASE_BITS = 3;
    // output beat width, rounded up to whole bytes
    localparam int OUT_BITS   = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

    // scan phases
    localparam logic [PHASE_BITS-1:0] PH_IDLE            = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_START_AUTO      = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_START_FIXED     = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_AFTER_SIGN_AUTO = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_AFTER_ZERO      = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_DIGITS          = 3'd5;

    // radix values
    localparam logic [BASE_BITS-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT = 5'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX = 5'd16;
    localparam logic [BASE_BITS-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_BITS-1:0] DIGIT_NONE = 5'd31;

    // characters of note
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;

    // scan state carried between beats
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [VALUE_BITS-1:0] acc;
        logic                  neg;
        logic [BASE_BITS-1:0]  base;
        logic [COUNT_BITS-1:0] count;
    } t_scan_state;

    // one finished result
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
    } t_result;

    // digit value of a character, DIGIT_NONE when it is no hex digit
    function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [BASE_BITS-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = BASE_BITS'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            d = BASE_BITS'(c - CH_LO_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = BASE_BITS'(c - CH_UP_A + 8'd10);
        end
        return d;
    endfunction

endpackage

[hw/rtl/sti_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_step
// Next scan state and optional result for one character: sign, prefix
// detection, digit check and one multiply-add into the accumulator.
// ----------------------------------------------------------------------------
module sti_step
    import sti_pkg::*;
(
    input  t_scan_state           i_state,
    input  logic [CHAR_BITS-1:0]  i_char,
    input  logic                  i_first,
    input  logic [BASE_BITS-1:0]  i_number_base,
    output t_scan_state           o_state,
    output t_result               o_result
);

    t_scan_state s;
    t_result     res;
    logic        handled;
    logic [BASE_BITS-1:0] d;
    logic [VALUE_BITS+BASE_BITS-1:0] prod;

    always_comb begin
        s       = i_state;
        res     = '0;
        handled = 1'b0;
        d       = digit_of(i_char);
        prod    = '0;

        // a first-flagged character opens a fresh scan
        if (i_first) begin
            s.acc   = '0;
            s.neg   = 1'b0;
            s.count = '0;
            if (i_number_base == BASE_AUTO) begin
                s.base  = BASE_DEC;
                s.phase = PH_START_AUTO;
            end else begin
                if (i_number_base < BASE_MIN) begin
                    s.base = BASE_MIN;
                end else if (i_number_base > BASE_HEX) begin
                    s.base = BASE_HEX;
                end else begin
                    s.base = i_number_base;
                end
                s.phase = PH_START_FIXED;
            end
        end

        if (s.phase != PH_IDLE) begin
            // optional sign
            if (s.phase == PH_START_AUTO || s.phase == PH_START_FIXED) begin
                s.phase = (s.phase == PH_START_AUTO) ? PH_AFTER_SIGN_AUTO : PH_DIGITS;
                if (i_char == CH_PLUS || i_char == CH_MINUS) begin
                    s.neg   = (i_char == CH_MINUS);
                    handled = 1'b1;
                end
            end
            // leading zero selects octal in auto mode
            if (!handled && s.phase == PH_AFTER_SIGN_AUTO) begin
                if (i_char == CH_ZERO) begin
                    s.base  = BASE_OCT;
                    s.phase = PH_AFTER_ZERO;
                    handled = 1'b1;
                end else begin
                    s.phase = PH_DIGITS;
                end
            end
            // 0x / 0X selects hex
            if (!handled && s.phase == PH_AFTER_ZERO) begin
                s.phase = PH_DIGITS;
                if (i_char == CH_LO_X || i_char == CH_UP_X) begin
                    s.base  = BASE_HEX;
                    handled = 1'b1;
                end
            end
            // digit or terminator
            if (!handled) begin
                if (s.phase == PH_DIGITS && d < s.base) begin
                    prod    = s.acc * s.base + (VALUE_BITS+BASE_BITS)'(d);
                    s.acc   = prod[VALUE_BITS-1:0];
                    handled = 1'b1;
                end else begin
                    res.valid = 1'b1;
                    res.value = s.neg ? (~s.acc + 1'b1) : s.acc;
                    res.count = s.count;
                    s.phase   = PH_IDLE;
                end
            end
            // saturating count of consumed characters
            if (handled && s.count != '1) begin
                s.count = s.count + 1'b1;
            end
        end
    end

    assign o_state  = s;
    assign o_result = res;

endmodule

[hw/rtl/string_to_integer_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming strtol-style parser: one character per beat in, one signed
// value and consumed count out per terminated string.
// ----------------------------------------------------------------------------
// A terminating character passes the input register, then the result register.
// Throughput: 1 character per cycle unless the result slot stalls; one 32x5
//   multiply-add per character between the input and scan/result registers.
// Reset: synchronous, active low; clears the scan, both beat registers and
//   the base register (auto mode). No clearing pass.
module string_to_integer_parser
    import sti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: number_base
    input  logic                 i_cfg_we,
    input  logic [BASE_BITS-1:0] i_cfg_wdata,
    // character stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_BITS-1:0] s_axis_tdata,   // [7:0] char_code
    input  logic                 s_axis_tuser,   // [0] starts_string
    // result stream out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_BITS-1:0]  m_axis_tdata    // [31:0] parsed_value, [47:32] consumed_count
);

    logic                 r_number_base_we;
    logic [BASE_BITS-1:0] r_number_base;
    logic                 r_in_valid;
    logic [CHAR_BITS-1:0] r_in_char;
    logic                 r_in_first;
    t_scan_state          r_state;
    t_scan_state          n_state;
    t_result              step_res;
    logic                 r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                 adv;
    logic                 in_beat;

    assign r_number_base_we = i_cfg_we;

    // base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_AUTO;
        end else if (r_number_base_we) begin
            r_number_base <= i_cfg_wdata;
        end
    end

    // the held character moves on whenever the result slot is free or drains
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_char  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
        end
    end

    sti_step u_step (
        .i_state       (r_state),
        .i_char        (r_in_char),
        .i_first       (r_in_first),
        .i_number_base (r_number_base),
        .o_state       (n_state),
        .o_result      (step_res)
    );

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, acc: '0, neg: 1'b0, base: BASE_DEC, count: '0};
        end else if (r_in_valid && adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && step_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid && step_res.valid) begin
            r_out_value <= step_res.value;
            r_out_count <= step_res.count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_BITS'({r_out_count, r_out_value});

endmodule

[hw/rtl/sti_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_checker
// Port-level checks on the parser: result hold, reset, latency and
// input readiness while the result slot is empty.
// ----------------------------------------------------------------------------
module sti_checker
    import sti_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_BITS-1:0] m_axis_tdata
);

    // a stalled result beat holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // reset empties the result slot
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a fresh result follows an earlier accepted input beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input beat");

    // input is never held off while no result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result slot");

endmodule

bind string_to_integer_parser sti_checker u_sti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the string to integer parser. Character beats are
// fed from a queue. A scan predictor in the bench works out each result as a
// beat is taken, and the result beats are checked in order against it. The
// run covers a short directed set, one long wrapping string, and random
// strings under several radix settings and flow-control patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import sti_pkg::*;

    localparam int N_PHASES      = 10;
    localparam int PHASE_CHARS   = 64;
    localparam int IDLE_PCT      = 74;
    localparam int BOTH_PCT      = 21;
    localparam int LONG_HOLD     = 200;
    localparam int LONG_RUN      = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int TIMEOUT_NS    = 1000000;

    typedef struct {
        logic [CHAR_BITS-1:0] code;
        logic                 first;
    } t_char_beat;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
    } t_parse_result;

    typedef enum int {
        TERM_NUL, TERM_SPACE, TERM_HIGH, TERM_LETTER,
        TERM_BIG_DIGIT, TERM_PUNCT, TERM_ANY, TERM_NONE
    } t_term_kind;

    // DUT ports, inputs all driven from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [BASE_BITS-1:0] i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [CHAR_BITS-1:0] s_axis_tdata  = '0;   // [7:0] char_code
    logic                 s_axis_tuser  = 1'b0; // [0] starts_string
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_axis_tdata;         // [31:0] parsed_value, [47:32] consumed_count

    // stimulus and scoreboard state
    t_char_beat    pending_chars[$];
    t_parse_result expected_results[$];
    t_char_beat    next_beat;
    t_parse_result want;
    int unsigned   chars_queued   = 0;
    int unsigned   chars_taken    = 0;
    int unsigned   results_seen   = 0;
    int unsigned   input_stalls   = 0;
    int unsigned   failures       = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    int            hold_left      = 0;
    logic          long_hold_req  = 1'b0;
    logic [BASE_BITS-1:0] base_setting = BASE_AUTO;
    logic [BASE_BITS-1:0] base_plan [N_PHASES];

    // predicted scan state
    logic [VALUE_BITS-1:0] pr_acc   = '0;
    logic                  pr_neg   = 1'b0;
    logic [BASE_BITS-1:0]  pr_radix = BASE_DEC;
    logic [PHASE_BITS-1:0] pr_phase = PH_IDLE;
    logic [COUNT_BITS-1:0] pr_count = '0;

    string_to_integer_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------
    function automatic logic [BASE_BITS-1:0] hex_value(input logic [CHAR_BITS-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return BASE_BITS'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            return BASE_BITS'(c - CH_LO_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            return BASE_BITS'(c - CH_UP_A + 8'd10);
        end
        return DIGIT_NONE;
    endfunction

    task automatic bump_count();
        if (pr_count != '1) begin
            pr_count = pr_count + 1'b1;
        end
    endtask

    task automatic parse_char(input logic [CHAR_BITS-1:0] c, input logic first);
        logic [BASE_BITS-1:0] d;
        t_parse_result        res;
        d = hex_value(c);
        // start of string: radix latched from the register now
        if (first) begin
            pr_acc   = '0;
            pr_neg   = 1'b0;
            pr_count = '0;
            if (base_setting == BASE_AUTO) begin
                pr_radix = BASE_DEC;
                pr_phase = PH_START_AUTO;
            end else begin
                pr_radix = (base_setting < BASE_MIN) ? BASE_MIN :
                           ((base_setting > BASE_HEX) ? BASE_HEX : base_setting);
                pr_phase = PH_START_FIXED;
            end
        end
        if (pr_phase == PH_IDLE) begin
            return;
        end
        // optional sign
        if (pr_phase == PH_START_AUTO || pr_phase == PH_START_FIXED) begin
            pr_phase = (pr_phase == PH_START_AUTO) ? PH_AFTER_SIGN_AUTO : PH_DIGITS;
            if (c == CH_PLUS || c == CH_MINUS) begin
                pr_neg = (c == CH_MINUS);
                bump_count();
                return;
            end
        end
        // leading zero picks octal in auto mode
        if (pr_phase == PH_AFTER_SIGN_AUTO) begin
            if (c == CH_ZERO) begin
                pr_radix = BASE_OCT;
                pr_phase = PH_AFTER_ZERO;
                bump_count();
                return;
            end
            pr_phase = PH_DIGITS;
        end
        // x or X after the zero picks hex
        if (pr_phase == PH_AFTER_ZERO) begin
            pr_phase = PH_DIGITS;
            if (c == CH_LO_X || c == CH_UP_X) begin
                pr_radix = BASE_HEX;
                bump_count();
                return;
            end
        end
        if (d < pr_radix) begin
            pr_acc = pr_acc * VALUE_BITS'(pr_radix) + VALUE_BITS'(d);
            bump_count();
            return;
        end
        // terminator
        res.value = pr_neg ? -pr_acc : pr_acc;
        res.count = pr_count;
        expected_results.push_back(res);
        pr_phase = PH_IDLE;
    endtask

    // ------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_chars.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_beat = pending_chars.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_beat.code;
                s_axis_tuser  <= next_beat.first;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (long_hold_req && hold_left == 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each character beat, check each result beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !s_axis_tready) begin
                input_stalls++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                chars_taken++;
                parse_char(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: parsed_value %0d, consumed_count %0d",
                           $signed(m_axis_tdata[VALUE_BITS-1:0]),
                           m_axis_tdata[VALUE_BITS +: COUNT_BITS]);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[VALUE_BITS-1:0] !== want.value) begin
                        $error("parsed_value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_axis_tdata[VALUE_BITS-1:0]));
                        failures++;
                    end
                    if (m_axis_tdata[VALUE_BITS +: COUNT_BITS] !== want.count) begin
                        $error("consumed_count: expected %0d, got %0d",
                               want.count, m_axis_tdata[VALUE_BITS +: COUNT_BITS]);
                        failures++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [CHAR_BITS-1:0] c, input logic first);
        t_char_beat b;
        b.code  = c;
        b.first = first;
        pending_chars.push_back(b);
        chars_queued++;
    endtask

    task automatic queue_text(input string s, input logic [CHAR_BITS-1:0] term,
                              input logic with_term);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == 0);
        end
        if (with_term) begin
            push_char(term, s.len() == 0);
        end
    endtask

    function automatic logic [CHAR_BITS-1:0] digit_char(input int v);
        if (v < 10) begin
            return CH_ZERO + CHAR_BITS'(v);
        end
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CHAR_BITS'(v - 10);
    endfunction

    // one random string shaped for the given register value
    task automatic queue_string(input logic [BASE_BITS-1:0] cfg, output int len);
        logic [CHAR_BITS-1:0] txt[$];
        int                   radix;
        int                   n;
        t_term_kind           kind;
        radix = (cfg == BASE_AUTO) ? 10 : ((cfg < BASE_MIN) ? 2 : ((cfg > BASE_HEX) ? 16 : cfg));
        n = $urandom_range(0, 3);
        if (n == 1) begin
            txt.push_back(CH_PLUS);
        end else if (n == 2) begin
            txt.push_back(CH_MINUS);
        end
        // prefixes, mostly in auto mode; a fixed radix stops at the x
        n = $urandom_range(0, 9);
        if (n < 2 || (cfg == BASE_AUTO && n < 7)) begin
            txt.push_back(CH_ZERO);
            if (cfg == BASE_AUTO) begin
                radix = 8;
            end
            if ($urandom_range(0, 2) != 0) begin
                txt.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                if (cfg == BASE_AUTO) begin
                    radix = 16;
                end
            end
        end
        // mostly short digit runs, now and then long enough to wrap
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 36) : $urandom_range(0, 7);
        for (int i = 0; i < n; i++) begin
            txt.push_back(digit_char($urandom_range(0, radix - 1)));
        end
        kind = t_term_kind'($urandom_range(0, 7));
        case (kind)
            TERM_NUL:    txt.push_back(8'h00);
            TERM_SPACE:  txt.push_back(8'h20);
            TERM_HIGH:   txt.push_back(8'h80 | CHAR_BITS'($urandom_range(0, 127)));
            TERM_LETTER: txt.push_back(CHAR_BITS'($urandom_range(8'h67, 8'h7A)));
            TERM_BIG_DIGIT: begin
                txt.push_back((radix < 16) ? digit_char($urandom_range(radix, 15)) : 8'h2E);
            end
            TERM_PUNCT:  txt.push_back(CHAR_BITS'($urandom_range(8'h21, 8'h2F)));
            TERM_ANY:    txt.push_back(CHAR_BITS'($urandom_range(0, 255)));
            default: ; // left open, the next start drops it
        endcase
        if (txt.size() == 0) begin
            txt.push_back(8'h00);
        end
        for (int i = 0; i < txt.size(); i++) begin
            push_char(txt[i], i == 0);
        end
        len = txt.size();
    endtask

    // random strings with some raw noise in between
    task automatic queue_random(input int target);
        int done;
        int len;
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    push_char(CHAR_BITS'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end else begin
                queue_string(base_setting, len);
                done += len;
            end
        end
    endtask

    // wait for all queued beats to go in and all results to come out
    task automatic drain();
        int waited;
        waited = 0;
        while ((chars_taken != chars_queued || expected_results.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            $error("stream did not drain, %0d results still expected",
                   expected_results.size());
            failures++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_BITS-1:0] b);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        base_setting = b;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        base_plan = '{BASE_AUTO, BASE_DEC, BASE_HEX, BASE_MIN, BASE_OCT,
                      5'd1, 5'd31, 5'd17, 5'd7, BASE_AUTO};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed set, auto radix from reset
        queue_text("0x1F", 8'h00, 1'b1);  // hex prefix
        queue_text("-017", 8'h20, 1'b1);  // octal with sign
        queue_text("+0X", 8'h80, 1'b1);   // prefix only, non-ASCII end
        queue_text("-", 8'h00, 1'b1);     // sign only
        queue_text("0", "9", 1'b1);       // 9 is no octal digit
        push_char("q", 1'b0);             // no open scan, ignored
        queue_text("45", 8'h00, 1'b0);    // dropped by the restart
        queue_text("7", 8'hFF, 1'b1);
        queue_text("", "A", 1'b1);        // ends at once
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_base(base_plan[ph]);
            case (ph % 4)
                0: begin src_idle_pct = 0;        sink_stall_pct = 0;        end
                1: begin src_idle_pct = IDLE_PCT; sink_stall_pct = 0;        end
                2: begin src_idle_pct = 0;        sink_stall_pct = IDLE_PCT; end
                default: begin src_idle_pct = BOTH_PCT; sink_stall_pct = BOTH_PCT; end
            endcase
            if (ph == 0) begin
                // one long string: the value wraps
                push_char(CH_MINUS, 1'b1);
                for (int i = 0; i < LONG_RUN; i++) begin
                    push_char(CH_NINE, 1'b0);
                end
                push_char(8'h00, 1'b0);
            end
            if (ph == 4) begin
                // sink holds off while characters keep coming, then the
                // sender waits for everything to come out
                long_hold_req = 1'b1;
                @(negedge i_clk);
                long_hold_req = 1'b0;
                queue_random(PHASE_CHARS / 2);
                drain();
                queue_random(PHASE_CHARS - PHASE_CHARS / 2);
            end else begin
                queue_random(PHASE_CHARS);
            end
            drain();
        end

        drain();
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        $display("Covered %0d character beats and %0d results over %0d radix settings,",
                 chars_taken, results_seen, N_PHASES + 1);
        $display("with %0d cycles of input back-pressure and %0d failures.",
                 input_stalls, failures);
        if (failures == 0) begin
            $display("** string_to_integer_parser: PASSED **");
        end else begin
            $display("** string_to_integer_parser: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("** string_to_integer_parser: FAILED **");
        $finish;
    end

endmodule
